### hw/rtl/snapshot_version_filter_macros.svh
// Assertion helpers for the snapshot version filter.
`ifndef SNAPSHOT_VERSION_FILTER_MACROS_SVH
`define SNAPSHOT_VERSION_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svf assertion failed");

// next-cycle implication
`define SVF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svf assertion failed");

`else

`define SVF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SVF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/svf_pkg.sv
package svf_pkg;

  typedef enum logic [1:0] {
    KIND_VISIBLE = 2'd0,
    KIND_END     = 2'd1,
    KIND_CORRUPT = 2'd2
  } kind_t;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SNAPSHOT_SEQ = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCAN_REVERSE = 1'b1;

  // one entry causes at most three results
  localparam int MAX_RES  = 3;
  localparam int RES_BITS = 2;

endpackage

### hw/rtl/svf_if.sv
interface svf_in_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int SEQ_BITS   = 56
);
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS-1:0]   entry_key;
  logic [SEQ_BITS-1:0]   entry_seq;
  logic                  entry_is_value;
  logic [VALUE_BITS-1:0] entry_value;
  logic                  entry_malformed;
  logic                  last_entry;

  modport source (
    output valid, entry_key, entry_seq, entry_is_value, entry_value,
           entry_malformed, last_entry,
    input  ready
  );
  modport sink (
    input  valid, entry_key, entry_seq, entry_is_value, entry_value,
           entry_malformed, last_entry,
    output ready
  );
endinterface

interface svf_out_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            result_kind;
  logic [KEY_BITS-1:0]   out_key;
  logic [VALUE_BITS-1:0] out_value;
  logic                  last_of_run;

  modport source (
    output valid, result_kind, out_key, out_value, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_key, out_value, last_of_run,
    output ready
  );
endinterface

### hw/rtl/snapshot_version_filter.sv
// Snapshot visibility filter: takes one stored version per cycle unless held by
// a busy result queue, and returns the newest version of each key visible at
// snapshot_seq, plus corruption and end of scan results, which leave from a
// registered result queue. An entry causing k results (k up to three) holds the
// result port until all k are taken, one result transfer per cycle while ready is
// high; entries causing no result pass without the port. An input register in front of
// the filter logic takes one more entry while results are stalled at the output.
`include "snapshot_version_filter_macros.svh"

module snapshot_version_filter import svf_pkg::*; #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int SEQ_BITS   = 56
) (
  input  logic                    clk,
  input  logic                    rst_n,
  svf_in_if.sink                  in_entry,
  svf_out_if.source               out_result,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [SEQ_BITS-1:0]     cfg_data
);

  // configuration
  logic [SEQ_BITS-1:0] snap_r;
  logic                rev_r;

  // input stage
  logic                  e_vld_r;
  logic [KEY_BITS-1:0]   e_key_r;
  logic [SEQ_BITS-1:0]   e_seq_r;
  logic                  e_isv_r;
  logic [VALUE_BITS-1:0] e_val_r;
  logic                  e_mal_r;
  logic                  e_last_r;

  // scan state
  logic                  held_r, held_nxt;
  logic [KEY_BITS-1:0]   hkey_r, hkey_nxt;
  logic [VALUE_BITS-1:0] hval_r, hval_nxt;
  logic                  stop_r, stop_nxt;

  // results of the entry in the input stage
  logic [RES_BITS-1:0]   n_res;
  kind_t                 res_kind [MAX_RES];
  logic [KEY_BITS-1:0]   res_key  [MAX_RES];
  logic [VALUE_BITS-1:0] res_val  [MAX_RES];

  // result queue, head in slot 0
  logic [RES_BITS-1:0]   cnt_r;
  kind_t                 slot_kind_r [MAX_RES];
  logic [KEY_BITS-1:0]   slot_key_r  [MAX_RES];
  logic [VALUE_BITS-1:0] slot_val_r  [MAX_RES];

  logic in_xfer, pop, q_free, advance, load;

  assign pop     = out_result.valid && out_result.ready;
  assign q_free  = (cnt_r == '0) || ((cnt_r == RES_BITS'(1)) && pop);
  assign advance = e_vld_r && ((n_res == '0) || q_free);
  assign load    = advance && (n_res != '0);
  assign in_entry.ready = !e_vld_r || advance;
  assign in_xfer = in_entry.valid && in_entry.ready;

  always_comb begin
    n_res = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_kind[i] = KIND_VISIBLE;
      res_key[i]  = '0;
      res_val[i]  = '0;
    end
    held_nxt = held_r;
    hkey_nxt = hkey_r;
    hval_nxt = hval_r;
    stop_nxt = stop_r;

    if (!stop_r) begin
      if (e_mal_r) begin
        res_kind[n_res] = KIND_CORRUPT;
        n_res    = n_res + RES_BITS'(1);
        stop_nxt = 1'b1;
        held_nxt = 1'b0;
        hkey_nxt = '0;
        hval_nxt = '0;
      end else if (e_seq_r <= snap_r) begin
        if (!rev_r) begin
          // forward: first visible version wins, later versions of the key skipped
          if (!e_isv_r) begin
            hkey_nxt = e_key_r;
            held_nxt = 1'b1;
          end else if (!(held_r && e_key_r <= hkey_r)) begin
            res_kind[n_res] = KIND_VISIBLE;
            res_key[n_res]  = e_key_r;
            res_val[n_res]  = e_val_r;
            n_res    = n_res + RES_BITS'(1);
            hkey_nxt = e_key_r;
            held_nxt = 1'b1;
          end
        end else begin
          // reverse: candidate is released when a smaller key shows up
          if (held_r && e_key_r < hkey_r) begin
            res_kind[n_res] = KIND_VISIBLE;
            res_key[n_res]  = hkey_r;
            res_val[n_res]  = hval_r;
            n_res    = n_res + RES_BITS'(1);
          end
          if (e_isv_r) begin
            held_nxt = 1'b1;
            hkey_nxt = e_key_r;
            hval_nxt = e_val_r;
          end else begin
            held_nxt = 1'b0;
            hkey_nxt = '0;
            hval_nxt = '0;
          end
        end
      end
    end

    if (e_last_r) begin
      if (!stop_nxt && rev_r && held_nxt) begin
        res_kind[n_res] = KIND_VISIBLE;
        res_key[n_res]  = hkey_nxt;
        res_val[n_res]  = hval_nxt;
        n_res = n_res + RES_BITS'(1);
      end
      res_kind[n_res] = KIND_END;
      n_res    = n_res + RES_BITS'(1);
      held_nxt = 1'b0;
      hkey_nxt = '0;
      hval_nxt = '0;
      stop_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_r  <= '1;
      rev_r   <= 1'b0;
      e_vld_r <= 1'b0;
      held_r  <= 1'b0;
      hkey_r  <= '0;
      hval_r  <= '0;
      stop_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_SNAPSHOT_SEQ: snap_r <= cfg_data;
          REG_SCAN_REVERSE: rev_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        e_vld_r <= 1'b1;
      end else if (advance) begin
        e_vld_r <= 1'b0;
      end
      if (advance) begin
        held_r <= held_nxt;
        hkey_r <= hkey_nxt;
        hval_r <= hval_nxt;
        stop_r <= stop_nxt;
      end
      if (load) begin
        cnt_r <= n_res;
      end else if (pop) begin
        cnt_r <= cnt_r - RES_BITS'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      e_key_r  <= in_entry.entry_key;
      e_seq_r  <= in_entry.entry_seq;
      e_isv_r  <= in_entry.entry_is_value;
      e_val_r  <= in_entry.entry_value;
      e_mal_r  <= in_entry.entry_malformed;
      e_last_r <= in_entry.last_entry;
    end
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slot_kind_r[i] <= res_kind[i];
        slot_key_r[i]  <= res_key[i];
        slot_val_r[i]  <= res_val[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot_kind_r[i] <= slot_kind_r[i+1];
        slot_key_r[i]  <= slot_key_r[i+1];
        slot_val_r[i]  <= slot_val_r[i+1];
      end
    end
  end

  assign out_result.valid       = (cnt_r != '0);
  assign out_result.result_kind = slot_kind_r[0];
  assign out_result.out_key     = slot_key_r[0];
  assign out_result.out_value   = slot_val_r[0];
  assign out_result.last_of_run = (cnt_r == RES_BITS'(1));

  `SVF_ASSERT_IMP(a_stop_drops_hold, clk, rst_n, stop_r, !held_r)
  `SVF_ASSERT_NXT(a_last_clears, clk, rst_n, advance && e_last_r, !stop_r && !held_r)
  `SVF_ASSERT_IMP(a_end_closes_run, clk, rst_n,
                  out_result.valid && out_result.result_kind == KIND_END,
                  out_result.last_of_run)
  `SVF_ASSERT_NXT(a_queue_drains, clk, rst_n,
                  pop && cnt_r == RES_BITS'(1) && !load, cnt_r == '0)

endmodule

### dv/snapshot_version_filter_tb.sv
module snapshot_version_filter_tb import svf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int SEQ_W       = 56;
  localparam int DRAIN_WAIT  = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic             is_value;
    logic [VAL_W-1:0] value;
    logic             malformed;
    logic             last;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
  } result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [SEQ_W-1:0]        cfg_data;

  svf_in_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W), .SEQ_BITS(SEQ_W)) in_ch ();
  svf_out_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) out_ch ();

  snapshot_version_filter #(
    .KEY_BITS  (KEY_W),
    .VALUE_BITS(VAL_W),
    .SEQ_BITS  (SEQ_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_entry  (in_ch),
    .out_result(out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  entry_t  entries_to_send[$];
  result_t results_due[$];

  // filter state as the block should hold it
  logic [SEQ_W-1:0] snap_seq;
  logic             reverse_mode;
  logic             key_held;
  logic [KEY_W-1:0] held_key;
  logic [VAL_W-1:0] held_value;
  logic             scan_stopped;

  int  errors;
  int  entries_taken;
  int  cfg_writes;
  int  kind_seen[3];
  int  idle_cycles;
  int  send_gap;
  int  stall_left;
  int  idle_odds;
  bit  idle_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t make_result(kind_t kind, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value);
    result_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void clear_scan();
    key_held     = 1'b0;
    held_key     = '0;
    held_value   = '0;
    scan_stopped = 1'b0;
  endfunction

  // Results one entry causes, in order: visible, corruption, end of scan.
  function automatic void filter_entry(entry_t e);
    result_t run[$];
    if (!scan_stopped) begin
      if (e.malformed) begin
        run.push_back(make_result(KIND_CORRUPT, '0, '0));
        scan_stopped = 1'b1;
        key_held     = 1'b0;
        held_key     = '0;
        held_value   = '0;
      end else if (e.seq <= snap_seq) begin
        if (!reverse_mode) begin
          if (!e.is_value) begin
            held_key = e.key;
            key_held = 1'b1;
          end else if (!(key_held && e.key <= held_key)) begin
            run.push_back(make_result(KIND_VISIBLE, e.key, e.value));
            held_key = e.key;
            key_held = 1'b1;
          end
        end else begin
          if (key_held && e.key < held_key) begin
            run.push_back(make_result(KIND_VISIBLE, held_key, held_value));
            key_held = 1'b0;
          end
          if (e.is_value) begin
            key_held   = 1'b1;
            held_key   = e.key;
            held_value = e.value;
          end else begin
            key_held   = 1'b0;
            held_key   = '0;
            held_value = '0;
          end
        end
      end
    end
    if (e.last) begin
      if (!scan_stopped && reverse_mode && key_held)
        run.push_back(make_result(KIND_VISIBLE, held_key, held_value));
      run.push_back(make_result(KIND_END, '0, '0));
      clear_scan();
    end
    if (run.size() != 0)
      run[run.size()-1].last = 1'b1;
    foreach (run[i])
      results_due.push_back(run[i]);
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  function automatic void push_entry(logic [KEY_W-1:0] key, logic [SEQ_W-1:0] seq,
                                     logic is_value, logic [VAL_W-1:0] value,
                                     logic malformed, logic last);
    entry_t e;
    e.key       = key;
    e.seq       = seq;
    e.is_value  = is_value;
    e.value     = value;
    e.malformed = malformed;
    e.last      = last;
    entries_to_send.push_back(e);
  endfunction

  // Sorted scan: ascending keys newest version first, or descending keys
  // oldest version first. A few entries come out malformed.
  task automatic queue_scan(bit descending, bit closed);
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seqs[$];
    int               n_keys;
    int               n_ver;
    n_keys = $urandom_range(2, 5);
    key    = {$urandom, $urandom};
    for (int k = 0; k < n_keys; k++) begin
      n_ver = $urandom_range(1, 4);
      seqs.delete();
      seqs.push_back(SEQ_W'($urandom_range(0, 400)));
      for (int v = 1; v < n_ver; v++)
        seqs.push_back(seqs[v-1] + SEQ_W'($urandom_range(1, 400)));
      for (int v = 0; v < n_ver; v++)
        push_entry(key, descending ? seqs[v] : seqs[n_ver-1-v], $urandom_range(0, 3) != 0,
                   {$urandom, $urandom}, $urandom_range(0, 39) == 0,
                   closed && k == n_keys - 1 && v == n_ver - 1);
      key = descending ? key - KEY_W'($urandom_range(1, 5000))
                       : key + KEY_W'($urandom_range(1, 5000));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SEQ_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SNAPSHOT_SEQ)
      snap_seq = data;
    else
      reverse_mode = data[0];
    cfg_writes++;
  endtask

  // block is idle once all entries are in and all results are out
  task automatic wait_idle();
    do @(negedge clk);
    while (entries_to_send.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // entry driver
  always @(posedge clk) begin : drive_entries
    entry_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (entries_to_send.size() != 0) begin
        nxt = entries_to_send.pop_front();
        in_ch.entry_key       <= nxt.key;
        in_ch.entry_seq       <= nxt.seq;
        in_ch.entry_is_value  <= nxt.is_value;
        in_ch.entry_value     <= nxt.value;
        in_ch.entry_malformed <= nxt.malformed;
        in_ch.last_entry      <= nxt.last;
        in_ch.valid           <= 1'b1;
        if (idle_enable && $urandom_range(0, idle_odds) == 0)
          send_gap <= $urandom_range(1, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_enable && $urandom_range(0, idle_odds) == 0)
        stall_left <= $urandom_range(1, 15);
    end
  end

  // monitor: predict on entry transfer, check on result transfer
  always @(posedge clk) begin : watch_ports
    entry_t  got_entry;
    result_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        got_entry.key       = in_ch.entry_key;
        got_entry.seq       = in_ch.entry_seq;
        got_entry.is_value  = in_ch.entry_is_value;
        got_entry.value     = in_ch.entry_value;
        got_entry.malformed = in_ch.entry_malformed;
        got_entry.last      = in_ch.last_entry;
        filter_entry(got_entry);
        entries_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.result_kind < 3)
          kind_seen[out_ch.result_kind]++;
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d key %0h value %0h",
                 out_ch.result_kind, out_ch.out_key, out_ch.out_value);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(out_ch.result_kind));
          check_field("out_key", want.key, out_ch.out_key);
          check_field("out_value", want.value, out_ch.out_value);
          check_field("last_of_run", 64'(want.last), 64'(out_ch.last_of_run));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("snapshot_version_filter regression: fail");
    $finish;
  end

  initial begin
    logic [SEQ_W-1:0] snap;
    bit               rev;
    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_idx               = REG_SNAPSHOT_SEQ;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.entry_key       = '0;
    in_ch.entry_seq       = '0;
    in_ch.entry_is_value  = 1'b0;
    in_ch.entry_value     = '0;
    in_ch.entry_malformed = 1'b0;
    in_ch.last_entry      = 1'b0;
    out_ch.ready          = 1'b0;
    errors                = 0;
    entries_taken         = 0;
    cfg_writes            = 0;
    kind_seen             = '{0, 0, 0};
    idle_enable           = 1'b1;
    idle_odds             = 3;
    snap_seq              = '1;
    reverse_mode          = 1'b0;
    clear_scan();

    // forward scan at the reset snapshot: extremes, tombstone, skipped versions
    push_entry('0, '1, 1'b1, '1, 1'b0, 1'b0);
    push_entry('0, 5, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(1, 10, 1'b0, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(1, 3, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry('1, '0, 1'b1, '0, 1'b0, 1'b0);
    push_entry('1, '0, 1'b0, {$urandom, $urandom}, 1'b0, 1'b1);
    // corruption stops output until the last entry
    push_entry(5, 2, 1'b1, {$urandom, $urandom}, 1'b1, 1'b0);
    push_entry(6, 2, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(7, 2, 1'b0, {$urandom, $urandom}, 1'b0, 1'b1);
    push_entry(8, 2, 1'b1, {$urandom, $urandom}, 1'b1, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    write_reg(REG_SNAPSHOT_SEQ, 100);
    write_reg(REG_SCAN_REVERSE, 1);
    @(negedge clk);
    // reverse scan: hidden versions, candidate replaced, three results at once
    push_entry(50, 200, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(50, 100, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(50, 101, 1'b0, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(40, 1, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(40, 2, 1'b0, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(30, 0, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(20, 5, 1'b1, {$urandom, $urandom}, 1'b0, 1'b1);
    // malformed entry drops the held candidate
    push_entry(10, 0, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(5, 0, 1'b1, {$urandom, $urandom}, 1'b1, 1'b0);
    push_entry(0, 0, 1'b0, {$urandom, $urandom}, 1'b0, 1'b1);
    // scan left open across a direction change
    push_entry(9, 1, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    wait_idle();

    write_reg(REG_SNAPSHOT_SEQ, '0);
    write_reg(REG_SCAN_REVERSE, 0);
    @(negedge clk);
    push_entry(9, 0, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(10, 0, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(11, 1, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    push_entry(12, 0, 1'b1, {$urandom, $urandom}, 1'b0, 1'b1);
    wait_idle();

    // random phases; the last two run without idling
    for (int p = 0; p < 8; p++) begin
      idle_enable = (p < 6);
      idle_odds   = $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0:       snap = '1;
        1:       snap = '0;
        2:       snap = SEQ_W'($urandom_range(0, 1500));
        default: snap = SEQ_W'({$urandom, $urandom});
      endcase
      if (p == 0)
        snap = '1;
      rev = 1'($urandom_range(0, 1));
      write_reg(REG_SNAPSHOT_SEQ, snap);
      write_reg(REG_SCAN_REVERSE, SEQ_W'(rev));
      @(negedge clk);
      queue_scan(rev, $urandom_range(0, 4) != 0);
      // noise: unsorted keys, full-width sequences, stray flags
      for (int s = 0; s < 3; s++)
        push_entry({$urandom, $urandom},
                   $urandom_range(0, 1) != 0 ? SEQ_W'({$urandom, $urandom})
                                             : SEQ_W'($urandom_range(0, 1500)),
                   1'($urandom_range(0, 1)), {$urandom, $urandom},
                   $urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0);
      // sometimes the wrong direction for the configured mode
      queue_scan(rev ^ ($urandom_range(0, 4) == 0), $urandom_range(0, 4) != 0);
      wait_idle();
    end

    $display("covered %0d entries over %0d register writes, both scan directions",
             entries_taken, cfg_writes);
    $display("checked %0d visible, %0d end-of-scan and %0d corruption results",
             kind_seen[0], kind_seen[1], kind_seen[2]);
    if (errors == 0)
      $display("snapshot_version_filter regression: pass");
    else
      $display("snapshot_version_filter regression: fail");
    $finish;
  end

endmodule
